@@ hw/rtl/hvd_pkg.sv @@
// Shared constants, types and functions for the haversine distance unit.
package hvd_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int CW = 36;
   localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
   localparam logic signed [CW-1:0] CORDIC_K = 36'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30 = 36'sd1073741824;
   localparam logic [31:0] TWO_R_CM = 32'd1274200000;
   localparam logic [30:0] HALF_CIRC_CM = 31'd2001508680;
   localparam logic [63:0] TURN_UNITS = 64'd3600000000;

   typedef logic signed [CW-1:0] q30_type;

   typedef struct packed {
      q30_type x;
      q30_type y;
      q30_type z;
   } cordic_type;

   function automatic q30_type atan_q30(input int i);
      q30_type r;
      r = '0;
      case (i)
         0: r = 36'sh03243F6A8;
         1: r = 36'sh01DAC6705;
         2: r = 36'sh00FADBAFC;
         3: r = 36'sh007F56EA6;
         4: r = 36'sh003FEAB76;
         5: r = 36'sh001FFD55B;
         6: r = 36'sh000FFFAAA;
         7: r = 36'sh0007FFF55;
         8: r = 36'sh0003FFFEA;
         9: r = 36'sh0001FFFFD;
         default: begin
            if (i <= 30) r = q30_type'((64'd1 << (30 - i)) - 64'd1);
         end
      endcase
      return r;
   endfunction

   function automatic q30_type mulq(input q30_type a, input q30_type b);
      logic [CW-1:0] ua;
      logic [CW-1:0] ub;
      logic [71:0] p;
      logic [CW-1:0] m;
      ua = a[CW-1] ? CW'(-a) : CW'(a);
      ub = b[CW-1] ? CW'(-b) : CW'(b);
      p = (72'(ua) * 72'(ub) + 72'd536870912) >> 30;
      m = p[CW-1:0];
      return (a[CW-1] ^ b[CW-1]) ? q30_type'(-m) : q30_type'(m);
   endfunction

endpackage

@@ hw/rtl/hvd_cell.sv @@
// One CORDIC cell: a registered micro-rotation in rotation or vectoring mode.
module hvd_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              vector_mode,
   input  hvd_pkg::cordic_type d_in,
   output hvd_pkg::cordic_type d_out
);
   hvd_pkg::cordic_type r_in;
   hvd_pkg::cordic_type r_ff;
   hvd_pkg::q30_type dx;
   hvd_pkg::q30_type dy;
   logic pos;

   always_comb begin
      dx = d_in.y >>> STEP;
      dy = d_in.x >>> STEP;
      pos = vector_mode ? !d_in.y[hvd_pkg::CW-1] : !d_in.z[hvd_pkg::CW-1];
      if (pos ^ vector_mode) begin
         r_in.x = d_in.x - dx;
         r_in.y = d_in.y + dy;
      end else begin
         r_in.x = d_in.x + dx;
         r_in.y = d_in.y - dy;
      end
      if (pos) r_in.z = vector_mode ? d_in.z + hvd_pkg::atan_q30(STEP)
                                    : d_in.z - hvd_pkg::atan_q30(STEP);
      else     r_in.z = vector_mode ? d_in.z - hvd_pkg::atan_q30(STEP)
                                    : d_in.z + hvd_pkg::atan_q30(STEP);
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign d_out = r_ff;
endmodule

@@ hw/rtl/hvd_chain.sv @@
// A row of CORDIC cells with a delay line carrying side data alongside.
module hvd_chain #(
   parameter int STEPS = hvd_pkg::CORDIC_STEPS_DEF,
   parameter int SW = 2
) (
   input  logic              clock,
   input  logic              vector_mode,
   input  hvd_pkg::cordic_type d_in,
   input  logic [SW-1:0]     side_in,
   output hvd_pkg::cordic_type d_out,
   output logic [SW-1:0]     side_out
);
   hvd_pkg::cordic_type link [STEPS+1];
   logic [SW-1:0] side_ff [STEPS];

   assign link[0] = d_in;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      hvd_cell #(.STEP(i)) u_cell (
         .clock(clock), .vector_mode(vector_mode),
         .d_in(link[i]), .d_out(link[i+1])
      );
      always_ff @(posedge clock) begin
         side_ff[i] <= (i == 0) ? side_in : side_ff[(i == 0) ? 0 : i-1];
      end
   end

   assign d_out = link[STEPS];
   assign side_out = side_ff[STEPS-1];
endmodule

@@ hw/rtl/hvd_sqrt.sv @@
// Pipelined integer square root of (v << 30), one result bit per cell, rounded.
module hvd_sqrt (
   input  logic        clock,
   input  logic [30:0] v,
   output logic [30:0] root
);
   localparam int N = 31;
   logic [61:0] rem_ff [1:N];
   logic [30:0] q_ff [1:N];
   logic [61:0] arg_ff [1:N-1];
   logic [31:0] r_last;

   for (genvar i = 0; i < N; i++) begin : g_bit
      logic [61:0] rem_cur;
      logic [30:0] q_cur;
      logic [61:0] arg_cur;
      logic [63:0] trial;
      logic [63:0] cur;
      if (i == 0) begin : g_head
         assign rem_cur = '0;
         assign q_cur = '0;
         assign arg_cur = {1'b0, v, 30'd0};
      end else begin : g_body
         assign rem_cur = rem_ff[i];
         assign q_cur = q_ff[i];
         assign arg_cur = arg_ff[i];
      end
      if (i < N - 1) begin : g_shift
         always_ff @(posedge clock) begin
            arg_ff[i+1] <= {arg_cur[59:0], 2'b00};
         end
      end
      assign cur = {rem_cur, arg_cur[61:60]};
      assign trial = 64'({q_cur, 2'b01});
      always_ff @(posedge clock) begin
         if (cur >= trial) begin
            rem_ff[i+1] <= 62'(cur - trial);
            q_ff[i+1] <= {q_cur[29:0], 1'b1};
         end else begin
            rem_ff[i+1] <= 62'(cur);
            q_ff[i+1] <= {q_cur[29:0], 1'b0};
         end
      end
   end

   always_comb begin
      r_last = {1'b0, q_ff[N]};
      if (64'(rem_ff[N]) > 64'(q_ff[N])) r_last = r_last + 32'd1;
      root = r_last[30:0];
   end
endmodule

@@ hw/rtl/haversine_distance_unit.sv @@
// Top level: pipelined haversine great-circle distance.
//  channel | ports                            | direction
//  request | start, busy, req_lat/lon_from/to | in; busy out
//  result  | rsp_valid, rsp_distance_cm       | out
// One word enters per cycle; busy stays low.
// A result follows its word through three phase stages, two CORDIC cell
// rows, four multiply stages, the 31-cell square root row and the output
// register.
// Reset clears the valid pipeline only; results cannot be stalled.
module haversine_distance_unit #(
   parameter int CORDIC_STEPS = hvd_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_lat_from,
   input  logic signed [31:0] req_lon_from,
   input  logic signed [30:0] req_lat_to,
   input  logic signed [31:0] req_lon_to,
   output logic               rsp_valid,
   output logic [30:0]        rsp_distance_cm
);
   localparam int LAT = 2 * CORDIC_STEPS + 39;
   localparam logic [54:0] PHASE_RECIP = 55'd21492014570926741;
   localparam logic [53:0] PHASE_BIAS = 54'd1757812;
   typedef logic [31:0] ph_type;
   typedef logic [53:0] num_type;

   // reduce modulo one turn (or two for a half angle), scale by 2^22 / 2^21
   function automatic num_type phase_num(input logic signed [33:0] x, input logic half);
      logic signed [35:0] xr;
      logic [35:0] per;
      logic [53:0] xu;
      per = half ? 36'(64'd2 * hvd_pkg::TURN_UNITS) : 36'(hvd_pkg::TURN_UNITS);
      xr = 36'(x);
      if (xr < 0) xr = xr + $signed(per);
      xu = 54'(xr);
      return half ? (xu << 21) + PHASE_BIAS : (xu << 22) + PHASE_BIAS;
   endfunction

   function automatic hvd_pkg::q30_type ph_z(input ph_type p);
      logic [63:0] t;
      t = (64'(p[29:0]) * 64'(hvd_pkg::HALFPI_Q30) + 64'd536870912) >> 30;
      return hvd_pkg::q30_type'(t);
   endfunction

   logic [LAT-1:0] vld_ff;
   num_type num_ff [4];
   hvd_pkg::cordic_type rot_in [4];
   hvd_pkg::cordic_type rot_out [4];
   logic [1:0] quad_out [4];
   hvd_pkg::q30_type sv [4];
   hvd_pkg::q30_type cv [4];
   hvd_pkg::q30_type hlat_ff, hlon_ff, c1_ff, c2_ff, cc_ff, hlon2_ff, p_ff;
   hvd_pkg::q30_type hlat_d1, hlat_d2;
   hvd_pkg::q30_type a_in;
   hvd_pkg::q30_type a_ff;
   logic [30:0] sa_root, ca_root;
   logic [30:0] a_u, na_u;
   hvd_pkg::cordic_type vec_in, vec_out;
   logic [0:0] zf_out;
   logic [63:0] d_in;
   logic [31:0] z_ff;
   logic zero_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start};
      num_ff[0] <= phase_num(34'(req_lat_to) - 34'(req_lat_from), 1'b1);
      num_ff[1] <= phase_num(34'(req_lon_to) - 34'(req_lon_from), 1'b1);
      num_ff[2] <= phase_num(34'(req_lat_from), 1'b0);
      num_ff[3] <= phase_num(34'(req_lat_to), 1'b0);
   end

   for (genvar k = 0; k < 4; k++) begin : g_sc
      logic [54:0] pp_hh_ff;
      logic [53:0] pp_hl_ff;
      logic [54:0] pp_lh_ff;
      logic [53:0] pp_ll_ff;
      logic [109:0] psum;
      ph_type ph_ff;

      // divide by one turn through the reciprocal, in split products
      always_ff @(posedge clock) begin
         pp_hh_ff <= 55'(num_ff[k][53:27]) * 55'(PHASE_RECIP[54:27]);
         pp_hl_ff <= 54'(num_ff[k][53:27]) * 54'(PHASE_RECIP[26:0]);
         pp_lh_ff <= 55'(num_ff[k][26:0]) * 55'(PHASE_RECIP[54:27]);
         pp_ll_ff <= 54'(num_ff[k][26:0]) * 54'(PHASE_RECIP[26:0]);
         ph_ff <= psum[107:76];
      end

      assign psum = (110'(pp_hh_ff) << 54) + (110'(pp_hl_ff) << 27)
                  + (110'(pp_lh_ff) << 27) + 110'(pp_ll_ff);

      assign rot_in[k] = '{x: hvd_pkg::CORDIC_K, y: '0, z: ph_z(ph_ff)};
      hvd_chain #(.STEPS(CORDIC_STEPS), .SW(2)) u_chain (
         .clock(clock), .vector_mode(1'b0), .d_in(rot_in[k]),
         .side_in(ph_ff[31:30]), .d_out(rot_out[k]), .side_out(quad_out[k])
      );
      always_comb begin
         case (quad_out[k])
            2'd0: begin cv[k] = rot_out[k].x; sv[k] = rot_out[k].y; end
            2'd1: begin cv[k] = -rot_out[k].y; sv[k] = rot_out[k].x; end
            2'd2: begin cv[k] = -rot_out[k].x; sv[k] = -rot_out[k].y; end
            default: begin cv[k] = rot_out[k].y; sv[k] = -rot_out[k].x; end
         endcase
      end
   end

   always_comb begin
      a_in = hlat_d2 + p_ff;
      if (a_in < 0) a_in = '0;
      if (a_in > hvd_pkg::ONE_Q30) a_in = hvd_pkg::ONE_Q30;
   end

   always_ff @(posedge clock) begin
      hlat_ff <= hvd_pkg::mulq(sv[0], sv[0]);
      hlon_ff <= hvd_pkg::mulq(sv[1], sv[1]);
      c1_ff <= cv[2];
      c2_ff <= cv[3];
      cc_ff <= hvd_pkg::mulq(c1_ff, c2_ff);
      hlon2_ff <= hlon_ff;
      p_ff <= hvd_pkg::mulq(cc_ff, hlon2_ff) + hvd_pkg::q30_type'(0);
      hlat_d1 <= hlat_ff;
      hlat_d2 <= hlat_d1;
      a_ff <= a_in;
   end

   assign a_u = a_ff[30:0];
   assign na_u = 31'(hvd_pkg::ONE_Q30 - a_ff);

   hvd_sqrt u_sqa (.clock(clock), .v(a_u), .root(sa_root));
   hvd_sqrt u_sqc (.clock(clock), .v(na_u), .root(ca_root));

   assign vec_in = '{x: hvd_pkg::q30_type'(ca_root), y: hvd_pkg::q30_type'(sa_root), z: '0};

   hvd_chain #(.STEPS(CORDIC_STEPS), .SW(1)) u_vec (
      .clock(clock), .vector_mode(1'b1), .d_in(vec_in),
      .side_in(sa_root == '0), .d_out(vec_out), .side_out(zf_out)
   );

   always_ff @(posedge clock) begin
      z_ff <= (zf_out[0] || vec_out.z < 0) ? '0 : vec_out.z[31:0];
      zero_ff <= 1'b0;
   end

   always_comb begin
      d_in = (64'(z_ff) * 64'(hvd_pkg::TWO_R_CM) + 64'd536870912) >> 30;
      if (d_in > 64'(hvd_pkg::HALF_CIRC_CM) || zero_ff) d_in = 64'(hvd_pkg::HALF_CIRC_CM);
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_distance_cm = d_in[30:0];
endmodule

@@ bench/haversine_distance_unit_tb.sv @@
// Self-checking testbench for the haversine distance unit: directed and random position pairs.
`timescale 1ns / 1ps

module haversine_distance_unit_tb;

   localparam int STEPS = 24;
   localparam int DRAIN_CYCLES = 2 * STEPS + 42 + 60;
   localparam int RANDOM_WORDS = 1300;
   localparam int QUIET_TAIL = 200;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint NO_VALUE = -1;

   typedef struct {
      longint lat_from;
      longint lon_from;
      longint lat_to;
      longint lon_to;
      longint dist_cm;
   } route_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [30:0] req_lat_from;
   logic signed [31:0] req_lon_from;
   logic signed [30:0] req_lat_to;
   logic signed [31:0] req_lon_to;
   logic               rsp_valid;
   logic [30:0]        rsp_distance_cm;

   logic [30:0] dist_queue[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   longint      cycle_count = 0;

   route_row_type route_rows[] = '{
      '{0, 0, 0, 0, 0},
      '{450000000, 1200000000, 450000000, 1200000000, 0},
      '{1073741823, 2147483647, 1073741823, 2147483647, 0},
      '{-1073741824, -2147483648, -1073741824, -2147483648, 0},
      '{900000000, 0, -900000000, 0, NO_VALUE},
      '{0, 0, 0, 1800000000, NO_VALUE},
      '{0, -1800000000, 0, 1800000000, NO_VALUE},
      '{1073741823, 0, -1073741824, 0, NO_VALUE},
      '{0, -2147483648, 0, 2147483647, NO_VALUE},
      '{0, 0, 1, 0, NO_VALUE},
      '{0, 0, 0, 1, NO_VALUE},
      '{-900000000, -1800000000, 900000000, 1800000000, NO_VALUE},
      '{900000000, 1234567, 900000000, -7654321, NO_VALUE},
      '{123456789, -987654321, -456789012, 1654321098, NO_VALUE},
      '{-1, -1, 0, 0, NO_VALUE},
      '{515000000, -1200000, 407000000, -740000000, NO_VALUE}
   };

   haversine_distance_unit #(.CORDIC_STEPS(STEPS)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_lat_from(req_lat_from),
      .req_lon_from(req_lon_from),
      .req_lat_to(req_lat_to),
      .req_lon_to(req_lon_to),
      .rsp_valid(rsp_valid),
      .rsp_distance_cm(rsp_distance_cm)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint atan_step(input int i);
      longint head[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                           64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                           64'h003FFFEA, 64'h001FFFFD};
      if (i < 10) return head[i];
      if (i <= 30) return (longint'(1) << (30 - i)) - 1;
      return 0;
   endfunction

   function automatic longint round_product(input longint a, input longint b);
      longint unsigned ua;
      longint unsigned ub;
      longint unsigned p;
      ua = (a < 0) ? longint'(-a) : a;
      ub = (b < 0) ? longint'(-b) : b;
      p = (ua * ub + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [31:0] turn_phase(input longint x, input bit half);
      longint period;
      longint xr;
      longint unsigned num;
      period = half ? 2 * 64'sd3600000000 : 64'sd3600000000;
      xr = x % period;
      if (xr < 0) xr += period;
      num = (longint'(xr) << (half ? 31 : 32)) + 64'd1800000000;
      return 32'(num / 64'd3600000000);
   endfunction

   function automatic void rotate_phase(input logic [31:0] ph, output longint s,
         output longint c);
      longint unsigned rem;
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      rem = ph[29:0];
      z = longint'((rem * 64'd1686629713 + 64'd536870912) >> 30);
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      case (ph[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint root_q30(input longint v);
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      n = longint'(v) << 30;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (n > r) r++;
      return longint'(r);
   endfunction

   function automatic longint central_angle(input longint y, input longint x);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   function automatic logic [30:0] great_circle_cm(input logic signed [30:0] lat1,
         input logic signed [31:0] lon1, input logic signed [30:0] lat2,
         input logic signed [31:0] lon2);
      longint s, c, c1, c2, hlat, hlon, a, sa, ca, z;
      longint unsigned d;
      rotate_phase(turn_phase(longint'(lat2) - longint'(lat1), 1'b1), s, c);
      hlat = round_product(s, s);
      rotate_phase(turn_phase(longint'(lon2) - longint'(lon1), 1'b1), s, c);
      hlon = round_product(s, s);
      rotate_phase(turn_phase(longint'(lat1), 1'b0), s, c1);
      rotate_phase(turn_phase(longint'(lat2), 1'b0), s, c2);
      a = hlat + round_product(round_product(c1, c2), hlon);
      if (a < 0) a = 0;
      if (a > 64'sd1073741824) a = 64'sd1073741824;
      sa = root_q30(a);
      ca = root_q30(64'sd1073741824 - a);
      z = (sa == 0) ? 0 : central_angle(sa, ca);
      if (z < 0) z = 0;
      d = (longint'(z) * 64'd1274200000 + 64'd536870912) >> 30;
      if (d > 64'd2001508680) d = 64'd2001508680;
      return d[30:0];
   endfunction

   task automatic send_word(input route_row_type row, input bit quiet);
      bit taken;
      logic [30:0] predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      start <= 1'b1;
      req_lat_from <= row.lat_from[30:0];
      req_lon_from <= row.lon_from[31:0];
      req_lat_to <= row.lat_to[30:0];
      req_lon_to <= row.lon_to[31:0];
      do begin
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      if (row.dist_cm != NO_VALUE) begin
         predicted = great_circle_cm(row.lat_from[30:0], row.lon_from[31:0],
                                     row.lat_to[30:0], row.lon_to[31:0]);
         if (predicted != row.dist_cm[30:0]) begin
            $error("distance_cm table row: expected %0d, actual %0d",
                   row.dist_cm, predicted);
            mismatches++;
         end
      end
      words_sent++;
   endtask

   function automatic route_row_type random_route();
      route_row_type r;
      case ($urandom_range(0, 5))
         0: begin
            r.lat_from = longint'($signed($urandom())) >>> 1;
            r.lon_from = longint'($signed($urandom()));
            r.lat_to = longint'($signed($urandom())) >>> 1;
            r.lon_to = longint'($signed($urandom()));
         end
         1, 2: begin
            r.lat_from = longint'($urandom_range(0, 1800000000)) - 900000000;
            r.lon_from = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
            r.lat_to = r.lat_from + longint'($urandom_range(0, 2000000)) - 1000000;
            r.lon_to = r.lon_from + longint'($urandom_range(0, 2000000)) - 1000000;
         end
         default: begin
            r.lat_from = longint'($urandom_range(0, 1800000000)) - 900000000;
            r.lon_from = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
            r.lat_to = longint'($urandom_range(0, 1800000000)) - 900000000;
            r.lon_to = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
         end
      endcase
      r.dist_cm = NO_VALUE;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("haversine_distance_unit test failed");
         $finish;
      end
      if (!reset) begin
         if (start && !busy)
            dist_queue.push_back(great_circle_cm(req_lat_from, req_lon_from,
                                                 req_lat_to, req_lon_to));
         if (rsp_valid) begin
            if (dist_queue.size() == 0) begin
               $error("distance_cm: unexpected word, actual %0d", rsp_distance_cm);
               mismatches++;
            end else begin
               if (rsp_distance_cm !== dist_queue[0]) begin
                  $error("distance_cm: expected %0d, actual %0d",
                         dist_queue[0], rsp_distance_cm);
                  mismatches++;
               end
               void'(dist_queue.pop_front());
               words_checked++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_lat_from = '0;
      req_lon_from = '0;
      req_lat_to = '0;
      req_lon_to = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (route_rows[i]) send_word(route_rows[i], 1'b0);
      for (int n = 0; n < RANDOM_WORDS; n++)
         send_word(random_route(), n >= RANDOM_WORDS - QUIET_TAIL);
      start <= 1'b0;
      while (dist_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (dist_queue.size() != 0) begin
         $error("distance_cm: %0d words never arrived", dist_queue.size());
         mismatches++;
      end
      $display("Sent %0d position pairs (table and random), checked %0d distances.",
               words_sent, words_checked);
      if (mismatches == 0) begin
         $display("haversine_distance_unit test passed");
      end else begin
         $display("haversine_distance_unit test failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/hvd_pkg.sv
hw/rtl/hvd_cell.sv
hw/rtl/hvd_chain.sv
hw/rtl/hvd_sqrt.sv
hw/rtl/haversine_distance_unit.sv
bench/haversine_distance_unit_tb.sv
